// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CGBN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("capped_greedy_box_nms: same-cycle assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CGBN_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("capped_greedy_box_nms: next-cycle assertion failed");

`endif

// ===== src/cgbn_pkg.sv =====
// ============================================================================
// cgbn_pkg: shared types and constants
// Sizes, the stored box record, register indexes, controller states and the
// command and status groups between controller and datapath.
// ============================================================================
`default_nettype none

package cgbn_pkg;

   localparam int MAX_BOXES   = 256;
   localparam int MAX_KEPT    = 64;
   localparam int NUM_CLASSES = 80;

   localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W  = $clog2(MAX_BOXES + 1);
   localparam int KIDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int KCNT_W = $clog2(MAX_KEPT + 1);
   localparam int CLS_AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

   localparam int CSR_AW = 5;

   typedef struct packed {
      logic signed [12:0] x;
      logic signed [12:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [15:0]        score;
      logic signed [7:0]  cls;
   } box_type;

   localparam int BOX_W = $bits(box_type);

   typedef enum logic [2:0] {
      CSR_IOU_THR      = 3'd0,
      CSR_SMALL_THR    = 3'd1,
      CSR_MEDIUM_THR   = 3'd2,
      CSR_MAX_DET      = 3'd3,
      CSR_PERSON_CAP   = 3'd4,
      CSR_FRAME_PIXELS = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] iou_thr;
      logic [15:0] small_thr;
      logic [15:0] medium_thr;
      logic [6:0]  max_det;
      logic [1:0]  person_cap;
      logic [23:0] frame_pixels;
   } csr_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SCAN,
      ST_SCAN_END,
      ST_PICK,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_CAP_MUL,
      ST_CAP_DEC,
      ST_CMP_RD,
      ST_CMP_GEO,
      ST_CMP_INT,
      ST_CMP_UNI,
      ST_CMP_PROD,
      ST_CMP_DEC,
      ST_KEEP,
      ST_OUT_RD,
      ST_OUT_LAT,
      ST_OUT_SEND
   } state_type;

   typedef struct packed {
      logic              load_we;
      logic              box_rd;
      logic [IDX_W-1:0]  box_addr;
      logic              scan_rd;
      logic              scan_clr;
      logic              frame_start;
      logic              take_best;
      logic              lat_d;
      logic              cls_rd;
      logic              cls_clr;
      logic [CLS_AW-1:0] cls_addr;
      logic              kept_rd;
      logic              keep;
      logic [KIDX_W-1:0] kept_addr;
      logic              out_lat;
      logic              out_empty;
      logic              out_last;
   } cmd_type;

   typedef struct packed {
      logic             best_found;
      logic [IDX_W-1:0] best_idx;
      logic             cap_skip;
      logic             suppress;
   } status_type;

endpackage

`default_nettype wire

// ===== src/cgbn_if.sv =====
// ============================================================================
// cgbn_req_if / cgbn_rsp_if: item channels
// Valid/ready channels carrying one detection box in and one kept box out.
// ============================================================================
`default_nettype none

interface cgbn_req_if;
   logic               valid;
   logic               ready;
   logic signed [12:0] box_x;
   logic signed [12:0] box_y;
   logic [11:0]        box_w;
   logic [11:0]        box_h;
   logic [15:0]        score;
   logic signed [7:0]  class_index;
   logic               last_box;

   modport source (output valid, box_x, box_y, box_w, box_h, score, class_index,
                   last_box, input ready);
   modport sink   (input valid, box_x, box_y, box_w, box_h, score, class_index,
                   last_box, output ready);
endinterface

interface cgbn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [12:0] kept_x;
   logic signed [12:0] kept_y;
   logic [11:0]        kept_w;
   logic [11:0]        kept_h;
   logic [15:0]        kept_score;
   logic signed [7:0]  kept_class;
   logic               valid_res;
   logic               last_kept;

   modport source (output valid, kept_x, kept_y, kept_w, kept_h, kept_score,
                   kept_class, valid_res, last_kept, input ready);
   modport sink   (input valid, kept_x, kept_y, kept_w, kept_h, kept_score,
                   kept_class, valid_res, last_kept, output ready);
endinterface

`default_nettype wire

// ===== src/capped_greedy_box_nms.sv =====
// ============================================================================
// capped_greedy_box_nms: capped greedy non-maximum suppression
// Top level: configuration registers, frame controller and datapath.
// ============================================================================
// The block takes one detection box per item, one item per cycle, until the
// item with last_box set; boxes beyond 256 in a frame are dropped. It then
// works on the frame with no input taken: a pass over the 80 classes clears
// the class counters, and the boxes are visited in descending score order
// (equal scores in arrival order). Each visit starts with a full read sweep
// of the box memory, one box per cycle, to find the next box in that order;
// then the box is fetched and the per-class cap test is run, then it is
// compared against each already kept box in turn; a box that passes them all
// is written to the kept list. A final sweep finds that no box is left or
// that the kept list is full. The box memory's single read port sets the pace
// of this work. Kept boxes then leave in keep order: each is read from the
// kept list, registered and offered, and the next is read only once it is
// taken; a frame with no kept box gives one item with valid_res low and
// last_kept high. The next frame is accepted in the cycle after the last
// result item is taken. Registers are written through the APB-style port at
// byte address 4*i and should only be changed while the block is idle.
// ============================================================================
`default_nettype none

module capped_greedy_box_nms import cgbn_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   cgbn_req_if.sink               req_ch,
   cgbn_rsp_if.source             rsp_ch,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   // Configuration registers. Writes complete in the access phase; the port
   // never inserts wait states.
   csr_type     csr_ff;
   csr_idx_type csr_idx;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.iou_thr      <= 16'd29491;
         csr_ff.small_thr    <= 16'd655;
         csr_ff.medium_thr   <= 16'd3277;
         csr_ff.max_det      <= 7'd64;
         csr_ff.person_cap   <= 2'd3;
         csr_ff.frame_pixels <= 24'd2073600;
      end else if (csr_write) begin
         case (csr_idx)
            CSR_IOU_THR:      csr_ff.iou_thr      <= csr_pwdata[15:0];
            CSR_SMALL_THR:    csr_ff.small_thr    <= csr_pwdata[15:0];
            CSR_MEDIUM_THR:   csr_ff.medium_thr   <= csr_pwdata[15:0];
            CSR_MAX_DET:      csr_ff.max_det      <= csr_pwdata[6:0];
            CSR_PERSON_CAP:   csr_ff.person_cap   <= csr_pwdata[1:0];
            CSR_FRAME_PIXELS: csr_ff.frame_pixels <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IOU_THR:      csr_prdata = {16'd0, csr_ff.iou_thr};
         CSR_SMALL_THR:    csr_prdata = {16'd0, csr_ff.small_thr};
         CSR_MEDIUM_THR:   csr_prdata = {16'd0, csr_ff.medium_thr};
         CSR_MAX_DET:      csr_prdata = {25'd0, csr_ff.max_det};
         CSR_PERSON_CAP:   csr_prdata = {30'd0, csr_ff.person_cap};
         CSR_FRAME_PIXELS: csr_prdata = {8'd0, csr_ff.frame_pixels};
         default:          csr_prdata = '0;
      endcase
   end

   // The controller sequences the frame; the datapath owns the memories and
   // box arithmetic, and reports the branch decisions and the best index.
   cmd_type    cmd;
   status_type status;

   cgbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_box),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .max_det   (csr_ff.max_det),
      .status    (status),
      .cmd       (cmd)
   );

   cgbn_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr_ff),
      .cmd            (cmd),
      .status         (status),
      .req_box_x      (req_ch.box_x),
      .req_box_y      (req_ch.box_y),
      .req_box_w      (req_ch.box_w),
      .req_box_h      (req_ch.box_h),
      .req_score      (req_ch.score),
      .req_class      (req_ch.class_index),
      .rsp_kept_x     (rsp_ch.kept_x),
      .rsp_kept_y     (rsp_ch.kept_y),
      .rsp_kept_w     (rsp_ch.kept_w),
      .rsp_kept_h     (rsp_ch.kept_h),
      .rsp_kept_score (rsp_ch.kept_score),
      .rsp_kept_class (rsp_ch.kept_class),
      .rsp_valid_res  (rsp_ch.valid_res),
      .rsp_last_kept  (rsp_ch.last_kept)
   );

endmodule

`default_nettype wire

// ===== src/cgbn_ram.sv =====
// ============================================================================
// cgbn_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds.
// ============================================================================
`default_nettype none

module cgbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic                                       re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/cgbn_ctrl.sv =====
// ============================================================================
// cgbn_ctrl: frame sequencer
// Loads a frame, repeatedly selects the next box in score order, runs the
// cap and overlap checks on it, and finally streams out the kept list.
// ============================================================================
`default_nettype none

module cgbn_ctrl import cgbn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [6:0] max_det,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [KCNT_W-1:0] kept_ff, kept_in;
   logic [KCNT_W-1:0] k_ff, k_in;
   logic [CLS_AW-1:0] clr_ff, clr_in;

   logic       accept;
   logic       room;
   logic       is_last;
   logic       kept_full;
   logic [7:0] limit;

   assign accept  = (state_ff == ST_LOAD) && req_valid;
   assign room    = loaded_ff < CNT_W'(MAX_BOXES);
   assign is_last = (kept_ff == '0) || (k_ff == kept_ff - KCNT_W'(1));
   assign limit   = (max_det < 7'(MAX_KEPT)) ? {1'b0, max_det} : 8'(MAX_KEPT);
   assign kept_full = 8'(kept_ff) >= limit;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (clr_ff == CLS_AW'(NUM_CLASSES - 1)) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (idx_ff == loaded_ff - CNT_W'(1)) state_in = ST_SCAN_END;
         end
         ST_SCAN_END:   state_in = ST_PICK;
         ST_PICK: begin
            if (!status.best_found || kept_full) begin
               state_in = (kept_ff == '0) ? ST_OUT_LAT : ST_OUT_RD;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH:      state_in = ST_FETCH_WAIT;
         ST_FETCH_WAIT: state_in = ST_CAP_MUL;
         ST_CAP_MUL:    state_in = ST_CAP_DEC;
         ST_CAP_DEC: begin
            if (status.cap_skip) state_in = ST_SCAN;
            else if (kept_ff == '0) state_in = ST_KEEP;
            else state_in = ST_CMP_RD;
         end
         ST_CMP_RD:     state_in = ST_CMP_GEO;
         ST_CMP_GEO:    state_in = ST_CMP_INT;
         ST_CMP_INT:    state_in = ST_CMP_UNI;
         ST_CMP_UNI:    state_in = ST_CMP_PROD;
         ST_CMP_PROD:   state_in = ST_CMP_DEC;
         ST_CMP_DEC: begin
            if (status.suppress) state_in = ST_SCAN;
            else if (k_ff == kept_ff - KCNT_W'(1)) state_in = ST_KEEP;
            else state_in = ST_CMP_RD;
         end
         ST_KEEP:       state_in = ST_SCAN;
         ST_OUT_RD:     state_in = ST_OUT_LAT;
         ST_OUT_LAT:    state_in = ST_OUT_SEND;
         ST_OUT_SEND: begin
            if (rsp_ready) state_in = is_last ? ST_LOAD : ST_OUT_RD;
         end
         default:       state_in = ST_LOAD;
      endcase
   end

   // Counters.
   always_comb begin
      loaded_in = loaded_ff;
      if (accept && room) loaded_in = loaded_ff + CNT_W'(1);
      if ((state_ff == ST_OUT_SEND) && rsp_ready && is_last) loaded_in = '0;

      idx_in = (state_ff == ST_SCAN) ? idx_ff + CNT_W'(1) : '0;
      clr_in = (state_ff == ST_CLEAR) ? clr_ff + CLS_AW'(1) : '0;

      kept_in = kept_ff;
      if (state_ff == ST_CLEAR) kept_in = '0;
      else if (state_ff == ST_KEEP) kept_in = kept_ff + KCNT_W'(1);

      k_in = k_ff;
      case (state_ff)
         ST_PICK, ST_CAP_DEC: k_in = '0;
         ST_CMP_DEC: begin
            if (!status.suppress) k_in = k_ff + KCNT_W'(1);
         end
         ST_OUT_SEND: begin
            if (rsp_ready) k_in = k_ff + KCNT_W'(1);
         end
         default: k_in = k_ff;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_LOAD);
      rsp_valid = (state_ff == ST_OUT_SEND);
      case (state_ff)
         ST_LOAD: cmd.box_addr = loaded_ff[IDX_W-1:0];
         ST_SCAN: cmd.box_addr = idx_ff[IDX_W-1:0];
         default: cmd.box_addr = status.best_idx;
      endcase
      cmd.load_we     = accept && room;
      cmd.scan_rd     = (state_ff == ST_SCAN);
      cmd.scan_clr    = (state_ff == ST_SCAN) && (idx_ff == '0);
      cmd.frame_start = (state_ff == ST_CLEAR);
      cmd.box_rd      = (state_ff == ST_FETCH);
      cmd.take_best   = (state_ff == ST_FETCH);
      cmd.lat_d       = (state_ff == ST_FETCH_WAIT);
      cmd.cls_rd      = (state_ff == ST_CAP_MUL);
      cmd.cls_clr     = (state_ff == ST_CLEAR);
      cmd.cls_addr    = clr_ff;
      cmd.kept_rd     = (state_ff == ST_CMP_RD) || (state_ff == ST_OUT_RD);
      cmd.keep        = (state_ff == ST_KEEP);
      cmd.kept_addr   = (state_ff == ST_KEEP) ? kept_ff[KIDX_W-1:0] : k_ff[KIDX_W-1:0];
      cmd.out_lat     = (state_ff == ST_OUT_LAT);
      cmd.out_empty   = (kept_ff == '0);
      cmd.out_last    = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         loaded_ff <= '0;
         idx_ff    <= '0;
         kept_ff   <= '0;
         k_ff      <= '0;
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         idx_ff    <= idx_in;
         kept_ff   <= kept_in;
         k_ff      <= k_in;
         clr_ff    <= clr_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cgbn_dp.sv =====
// ============================================================================
// cgbn_dp: box store, score selection and overlap arithmetic
// Holds the frame's boxes, the kept boxes and the per-class counts, and does
// the max-score search, the area cap test and the IoU test.
// ============================================================================
`default_nettype none

module cgbn_dp import cgbn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire csr_type            csr,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic signed [12:0] req_box_x,
   input  wire logic signed [12:0] req_box_y,
   input  wire logic [11:0]        req_box_w,
   input  wire logic [11:0]        req_box_h,
   input  wire logic [15:0]        req_score,
   input  wire logic signed [7:0]  req_class,
   output logic signed [12:0]      rsp_kept_x,
   output logic signed [12:0]      rsp_kept_y,
   output logic [11:0]             rsp_kept_w,
   output logic [11:0]             rsp_kept_h,
   output logic [15:0]             rsp_kept_score,
   output logic signed [7:0]       rsp_kept_class,
   output logic                    rsp_valid_res,
   output logic                    rsp_last_kept
);

   box_type box_wdata, box_rdata, kept_rdata, d_ff;
   logic [1:0] cnt_rdata;

   assign box_wdata = '{x: req_box_x, y: req_box_y, w: req_box_w, h: req_box_h,
                        score: req_score, cls: req_class};

   cgbn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (cmd.box_addr),
      .wdata (box_wdata),
      .re    (cmd.box_rd | cmd.scan_rd),
      .raddr (cmd.box_addr),
      .rdata (box_rdata)
   );

   cgbn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_KEPT)) u_kept_ram (
      .clock (clock),
      .we    (cmd.keep),
      .waddr (cmd.kept_addr),
      .wdata (d_ff),
      .re    (cmd.kept_rd),
      .raddr (cmd.kept_addr),
      .rdata (kept_rdata)
   );

   logic              d_in_range;
   logic [CLS_AW-1:0] d_cls_addr;

   assign d_in_range = !d_ff.cls[7] && (d_ff.cls[6:0] < 7'(NUM_CLASSES));
   assign d_cls_addr = d_ff.cls[CLS_AW-1:0];

   cgbn_ram #(.WIDTH(2), .DEPTH(NUM_CLASSES)) u_cls_ram (
      .clock (clock),
      .we    (cmd.cls_clr | (cmd.keep & d_in_range)),
      .waddr (cmd.cls_clr ? cmd.cls_addr : d_cls_addr),
      .wdata (cmd.cls_clr ? 2'd0 : cnt_rdata + 2'd1),
      .re    (cmd.cls_rd),
      .raddr (d_cls_addr),
      .rdata (cnt_rdata)
   );

   // Selection: the best box strictly below the previous pick in the order
   // (score descending, arrival ascending).
   logic             sv_ff;
   logic [IDX_W-1:0] sidx_ff;
   logic             prev_none_ff;
   logic [15:0]      ps_ff;
   logic [IDX_W-1:0] pi_ff;
   logic             found_ff;
   logic [15:0]      bs_ff;
   logic [IDX_W-1:0] bi_ff;
   logic             qual;

   assign qual = prev_none_ff || (box_rdata.score < ps_ff) ||
                 ((box_rdata.score == ps_ff) && (sidx_ff > pi_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         prev_none_ff <= 1'b1;
      end else begin
         sv_ff <= cmd.scan_rd;
         if (cmd.scan_clr) begin
            found_ff <= 1'b0;
         end else if (sv_ff && qual && (!found_ff || (box_rdata.score > bs_ff))) begin
            found_ff <= 1'b1;
         end
         if (cmd.frame_start) prev_none_ff <= 1'b1;
         else if (cmd.take_best) prev_none_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff <= cmd.box_addr;
      if (!cmd.scan_clr && sv_ff && qual && (!found_ff || (box_rdata.score > bs_ff))) begin
         bs_ff <= box_rdata.score;
         bi_ff <= sidx_ff;
      end
      if (cmd.take_best) begin
         ps_ff <= bs_ff;
         pi_ff <= bi_ff;
      end
      if (cmd.lat_d) d_ff <= box_rdata;
   end

   // Area cap products; d_ff is stable while they are used.
   logic [23:0] area_ff;
   logic [39:0] sp_ff, mp_ff;
   logic [1:0]  cap;

   always_ff @(posedge clock) begin
      area_ff <= d_ff.w * d_ff.h;
      sp_ff   <= csr.small_thr * csr.frame_pixels;
      mp_ff   <= csr.medium_thr * csr.frame_pixels;
   end

   always_comb begin
      if ({area_ff, 16'd0} < sp_ff) cap = 2'd1;
      else if ({area_ff, 16'd0} < mp_ff) cap = 2'd2;
      else cap = 2'd3;
      if ((d_ff.cls == 8'sd0) && (csr.person_cap < cap)) cap = csr.person_cap;
   end

   // Overlap pipeline against the kept box on the kept RAM's read port.
   logic signed [13:0] dl, dr, fl, fr, dt, db, ft, fb, x1, x2, y1, y2;
   logic signed [14:0] dx, dy;
   logic [11:0]        iw_ff, ih_ff;
   logic [23:0]        af_ff, inter_ff;
   logic [24:0]        uni_ff;
   logic [40:0]        prod_ff;
   logic               match_ff;

   always_comb begin
      dl = {d_ff.x[12], d_ff.x};
      dr = dl + $signed({2'b00, d_ff.w});
      fl = {kept_rdata.x[12], kept_rdata.x};
      fr = fl + $signed({2'b00, kept_rdata.w});
      dt = {d_ff.y[12], d_ff.y};
      db = dt + $signed({2'b00, d_ff.h});
      ft = {kept_rdata.y[12], kept_rdata.y};
      fb = ft + $signed({2'b00, kept_rdata.h});
      x1 = (dl > fl) ? dl : fl;
      x2 = (dr < fr) ? dr : fr;
      y1 = (dt > ft) ? dt : ft;
      y2 = (db < fb) ? db : fb;
      dx = {x2[13], x2} - {x1[13], x1};
      dy = {y2[13], y2} - {y1[13], y1};
   end

   always_ff @(posedge clock) begin
      iw_ff    <= (dx <= 15'sd0) ? 12'd0 : dx[11:0];
      ih_ff    <= (dy <= 15'sd0) ? 12'd0 : dy[11:0];
      af_ff    <= kept_rdata.w * kept_rdata.h;
      match_ff <= d_ff.cls[7] || kept_rdata.cls[7] || (d_ff.cls == kept_rdata.cls);
      inter_ff <= iw_ff * ih_ff;
      uni_ff   <= 25'(area_ff) + 25'(af_ff) - 25'(inter_ff);
      prod_ff  <= csr.iou_thr * uni_ff;
   end

   assign status.best_found = found_ff;
   assign status.best_idx   = bi_ff;
   assign status.cap_skip   = d_in_range && (cnt_rdata >= cap);
   assign status.suppress   = match_ff && (uni_ff != '0) &&
                              ({1'b0, inter_ff, 16'd0} > prod_ff);

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.out_lat) begin
         if (cmd.out_empty) begin
            rsp_kept_x     <= '0;
            rsp_kept_y     <= '0;
            rsp_kept_w     <= '0;
            rsp_kept_h     <= '0;
            rsp_kept_score <= '0;
            rsp_kept_class <= '0;
            rsp_valid_res  <= 1'b0;
         end else begin
            rsp_kept_x     <= kept_rdata.x;
            rsp_kept_y     <= kept_rdata.y;
            rsp_kept_w     <= kept_rdata.w;
            rsp_kept_h     <= kept_rdata.h;
            rsp_kept_score <= kept_rdata.score;
            rsp_kept_class <= kept_rdata.cls;
            rsp_valid_res  <= 1'b1;
         end
         rsp_last_kept <= cmd.out_last;
      end
   end

endmodule

`default_nettype wire

// ===== src/cgbn_checker.sv =====
// ============================================================================
// cgbn_checker: port-level checks
// Watches the item channels of the top level over time.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module cgbn_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic signed [12:0] rsp_kept_x,
   input wire logic [15:0]       rsp_kept_score,
   input wire logic              rsp_valid_res,
   input wire logic              rsp_last_kept
);

   // A waiting result is held until it is taken.
   `CGBN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CGBN_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
                    $stable(rsp_kept_x) && $stable(rsp_kept_score))
   // No new frame is loaded while results are being delivered.
   `CGBN_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   // The empty-frame item is always the only, and last, item of the frame.
   `CGBN_ASSERT_IMP(a_empty_last, clock, reset, rsp_valid && !rsp_valid_res, rsp_last_kept)
   // Loading resumes right after the last item of a frame is taken.
   `CGBN_ASSERT_NXT(a_reload, clock, reset, rsp_valid && rsp_ready && rsp_last_kept,
                    req_ready && !rsp_valid)

endmodule

bind capped_greedy_box_nms cgbn_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kept_x     (rsp_ch.kept_x),
   .rsp_kept_score (rsp_ch.kept_score),
   .rsp_valid_res  (rsp_ch.valid_res),
   .rsp_last_kept  (rsp_ch.last_kept)
);

`default_nettype wire
